// ----- design/rotate_scale_sprite_sampler_defines.svh -----
// assertion macros shared by the sprite sampler modules
`ifndef ROTATE_SCALE_SPRITE_SAMPLER_DEFINES_SVH
`define ROTATE_SCALE_SPRITE_SAMPLER_DEFINES_SVH

`ifndef SYNTH
`define RSS_ASSERT_IMPL(name, clk_s, rst_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("assertion failed");
`define RSS_ASSERT_NEXT(name, clk_s, rst_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define RSS_ASSERT_IMPL(name, clk_s, rst_s, pre, post)
`define RSS_ASSERT_NEXT(name, clk_s, rst_s, pre, post)
`endif

`endif

// ----- design/rss_pkg.sv -----
// types, constants and helper functions of the sprite sampler
package rss_pkg;

    localparam int DEF_MAX_TILE_COLS = 64;
    localparam int DEF_MAX_TILE_ROWS = 64;
    localparam int DEF_MAX_DEST_SPAN = 4096;

    localparam int RGBA_W  = 32;
    localparam int COORD_W = 6;
    localparam int DEST_W  = 14;
    localparam int IN_DATA_W = 72;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int SIZE_W = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_COS_ANGLE     = 3'd0,
        REG_SIN_ANGLE     = 3'd1,
        REG_INVERSE_SCALE = 3'd2,
        REG_PIVOT_COL     = 3'd3,
        REG_PIVOT_ROW     = 3'd4,
        REG_TILE_COLS     = 3'd5,
        REG_TILE_ROWS     = 3'd6,
        REG_TINT_SETTING  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [23:0]        inverse_scale;
        logic signed [16:0] pivot_col;
        logic signed [16:0] pivot_row;
        logic [6:0]         tile_cols;
        logic [6:0]         tile_rows;
        logic               tint_en;
        logic [31:0]        tint_rgba;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cos_angle:     16'sd16384,
        sin_angle:     16'sd0,
        inverse_scale: 24'd65536,
        pivot_col:     17'sd0,
        pivot_row:     17'sd0,
        tile_cols:     7'd64,
        tile_rows:     7'd64,
        tint_en:       1'b0,
        tint_rgba:     32'd0
    };

    typedef struct packed {
        logic                      sample;
        logic                      wr_ok;
        logic [COORD_W-1:0]        texel_col;
        logic [COORD_W-1:0]        texel_row;
        logic [RGBA_W-1:0]         texel_rgba;
        logic signed [DEST_W-1:0]  dest_dx;
        logic signed [DEST_W-1:0]  dest_dy;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // (a*ta + 127) / 255, divide done as add-shift, exact below 65535
    function automatic logic [7:0] tint_alpha(input logic [7:0] a, input logic [7:0] ta);
        logic [16:0] p;
        logic [17:0] t;
        p = ({9'b0, a} * {9'b0, ta}) + 17'd127;
        t = {1'b0, p} + {9'b0, p[16:8]} + 18'd1;
        return t[15:8];
    endfunction

endpackage

// ----- design/rss_ram.sv -----
// single-port ram with registered read
module rss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ----- design/rss_queue.sv -----
// short fifo between the accept side and the sampling pipeline
`include "rotate_scale_sprite_sampler_defines.svh"

module rss_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rss_pkg::q_item_t  in_item,
    input  logic              pop,
    output rss_pkg::q_item_t  head,
    output rss_pkg::q_status_t stat
);
    import rss_pkg::*;

    q_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    `RSS_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, push, count_reg < QCNT_W'(QUEUE_DEPTH))
    `RSS_ASSERT_IMPL(a_q_no_underflow, clk, rst_n, pop, count_reg != '0)

endmodule

// ----- design/rss_front.sv -----
// accept side: unpacks the beat, classifies it and clamps the offsets
module rss_front #(
    parameter int MAX_TILE_COLS = rss_pkg::DEF_MAX_TILE_COLS,
    parameter int MAX_TILE_ROWS = rss_pkg::DEF_MAX_TILE_ROWS,
    parameter int MAX_DEST_SPAN = rss_pkg::DEF_MAX_DEST_SPAN
) (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // texel_col, texel_row, texel_rgba, dest_dx, dest_dy
    input  logic [rss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                           s_axis_tuser,
    input  rss_pkg::q_status_t             stat,
    output logic                           push,
    output rss_pkg::q_item_t               item
);
    import rss_pkg::*;

    localparam logic signed [DEST_W-1:0] SPAN_HI = DEST_W'(MAX_DEST_SPAN);
    localparam logic signed [DEST_W-1:0] SPAN_LO = DEST_W'(-MAX_DEST_SPAN);

    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic signed [DEST_W-1:0] dx_raw;
    logic signed [DEST_W-1:0] dy_raw;

    function automatic logic signed [DEST_W-1:0] clamp_span(input logic signed [DEST_W-1:0] v);
        if (v > SPAN_HI)
        begin
            return SPAN_HI;
        end
        else if (v < SPAN_LO)
        begin
            return SPAN_LO;
        end
        return v;
    endfunction

    assign col    = s_axis_tdata[5:0];
    assign row    = s_axis_tdata[11:6];
    assign dx_raw = $signed(s_axis_tdata[57:44]);
    assign dy_raw = $signed(s_axis_tdata[71:58]);

    assign s_axis_tready = !stat.full;
    assign push          = s_axis_tvalid && !stat.full;

    always_comb
    begin
        item.sample     = (s_axis_tuser == OP_SAMPLE);
        item.wr_ok      = (int'(col) < MAX_TILE_COLS) && (int'(row) < MAX_TILE_ROWS);
        item.texel_col  = col;
        item.texel_row  = row;
        item.texel_rgba = s_axis_tdata[43:12];
        item.dest_dx    = clamp_span(dx_raw);
        item.dest_dy    = clamp_span(dy_raw);
    end

endmodule

// ----- design/rss_back.sv -----
// sampling pipeline: rotate, scale, round, tile lookup, tint, output register
`include "rotate_scale_sprite_sampler_defines.svh"

module rss_back #(
    parameter int MAX_TILE_COLS = rss_pkg::DEF_MAX_TILE_COLS,
    parameter int MAX_TILE_ROWS = rss_pkg::DEF_MAX_TILE_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rss_pkg::cfg_t               cfg,
    input  rss_pkg::q_item_t            head,
    input  rss_pkg::q_status_t          stat,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pixel_rgba
    output logic [rss_pkg::RGBA_W-1:0]  m_axis_tdata,
    // hit
    output logic                        m_axis_tuser
);
    import rss_pkg::*;

    localparam int DEPTH  = MAX_TILE_COLS * MAX_TILE_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
    localparam int ROW_W  = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam int PROD_W = 30;
    localparam int ROT_W  = 31;
    localparam int MUL_W  = 56;
    localparam int SUM_W  = 57;
    localparam int SX_W   = 27;
    localparam logic [SIZE_W-1:0] MAXC = SIZE_W'(MAX_TILE_COLS);
    localparam logic [SIZE_W-1:0] MAXR = SIZE_W'(MAX_TILE_ROWS);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< 29);

    logic adv;

    logic                     s1_valid_reg;
    q_item_t                  s1_item_reg;
    logic signed [PROD_W-1:0] s1_xc_reg;
    logic signed [PROD_W-1:0] s1_ys_reg;
    logic signed [PROD_W-1:0] s1_xs_reg;
    logic signed [PROD_W-1:0] s1_yc_reg;

    logic                     s2_valid_reg;
    q_item_t                  s2_item_reg;
    logic signed [ROT_W-1:0]  s2_px_reg;
    logic signed [ROT_W-1:0]  s2_py_reg;

    logic                     s3_valid_reg;
    q_item_t                  s3_item_reg;
    logic signed [MUL_W-1:0]  s3_tx_reg;
    logic signed [MUL_W-1:0]  s3_ty_reg;

    logic                     s4_valid_reg;
    logic                     s4_hit_reg;

    logic                     m_valid_reg;
    logic [RGBA_W-1:0]        m_data_reg;
    logic                     m_hit_reg;

    logic signed [24:0]       inv_s;
    logic signed [SUM_W-1:0]  tx;
    logic signed [SUM_W-1:0]  ty;
    logic signed [SX_W-1:0]   sx;
    logic signed [SX_W-1:0]   sy;
    logic [SIZE_W-1:0]        cols_eff;
    logic [SIZE_W-1:0]        rows_eff;
    logic                     hit;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        ram_addr;
    logic                     ram_we;
    logic [RGBA_W-1:0]        ram_rdata;
    logic [RGBA_W-1:0]        pix;

    assign adv = !m_valid_reg || m_axis_tready;
    assign pop = adv && !stat.empty;

    assign inv_s = $signed({1'b0, cfg.inverse_scale});

    // back-mapped position rounded to the nearest texel
    assign tx = SUM_W'(s3_tx_reg) + (SUM_W'(cfg.pivot_col) <<< 26) + HALF;
    assign ty = SUM_W'(s3_ty_reg) + (SUM_W'(cfg.pivot_row) <<< 26) + HALF;
    assign sx = SX_W'(tx >>> 30);
    assign sy = SX_W'(ty >>> 30);

    assign cols_eff = (SIZE_W'(cfg.tile_cols) > MAXC) ? MAXC : SIZE_W'(cfg.tile_cols);
    assign rows_eff = (SIZE_W'(cfg.tile_rows) > MAXR) ? MAXR : SIZE_W'(cfg.tile_rows);

    assign hit = !sx[SX_W-1] && !sy[SX_W-1]
                 && (sx < SX_W'($signed({1'b0, cols_eff})))
                 && (sy < SX_W'($signed({1'b0, rows_eff})));

    assign rd_addr = ADDR_W'(int'(sy[ROW_W-1:0]) * MAX_TILE_COLS + int'(sx[COL_W-1:0]));
    assign wr_addr = ADDR_W'(int'(s3_item_reg.texel_row) * MAX_TILE_COLS
                             + int'(s3_item_reg.texel_col));
    assign ram_addr = s3_item_reg.sample ? rd_addr : wr_addr;
    assign ram_we   = s3_valid_reg && !s3_item_reg.sample && s3_item_reg.wr_ok;

    rss_ram #(
        .WIDTH (RGBA_W),
        .DEPTH (DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .en    (adv),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s3_item_reg.texel_rgba),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pix = '0;
        if (s4_hit_reg)
        begin
            if (cfg.tint_en)
            begin
                pix = {tint_alpha(ram_rdata[31:24], cfg.tint_rgba[31:24]),
                       cfg.tint_rgba[23:0]};
            end
            else
            begin
                pix = ram_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !stat.empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && s3_item_reg.sample;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= head;
            s1_xc_reg   <= PROD_W'(head.dest_dx) * PROD_W'(cfg.cos_angle);
            s1_ys_reg   <= PROD_W'(head.dest_dy) * PROD_W'(cfg.sin_angle);
            s1_xs_reg   <= PROD_W'(head.dest_dx) * PROD_W'(cfg.sin_angle);
            s1_yc_reg   <= PROD_W'(head.dest_dy) * PROD_W'(cfg.cos_angle);

            s2_item_reg <= s1_item_reg;
            s2_px_reg   <= ROT_W'(s1_xc_reg) - ROT_W'(s1_ys_reg);
            s2_py_reg   <= ROT_W'(s1_xs_reg) + ROT_W'(s1_yc_reg);

            s3_item_reg <= s2_item_reg;
            s3_tx_reg   <= MUL_W'(s2_px_reg) * MUL_W'(inv_s);
            s3_ty_reg   <= MUL_W'(s2_py_reg) * MUL_W'(inv_s);

            s4_hit_reg  <= hit;

            m_data_reg  <= pix;
            m_hit_reg   <= s4_hit_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_hit_reg;

    `RSS_ASSERT_NEXT(a_sample_reaches_out, clk, rst_n, adv && s4_valid_reg, m_valid_reg)
    `RSS_ASSERT_IMPL(a_miss_is_clear, clk, rst_n, m_valid_reg && !m_hit_reg, m_data_reg == '0)

endmodule

// ----- design/rotate_scale_sprite_sampler.sv -----
// top level of the rotate and scale sprite sampler
//
// Nearest-neighbor sprite sampler. Beats with op 0 load one RGBA texel into
// the on-chip tile store and give no output beat; beats with op 1 map a
// destination offset back through the configured rotation, inverse scale and
// pivot, and return the chosen texel (optionally tinted) with hit set, or
// zero with hit clear when the point falls outside the tile. When the output
// side is not stalled, the block takes one beat per clock and gives one
// output beat per clock for op 1 beats. A beat is written into the input
// queue, then passes through the five stages: the rotate multiply, the
// rotate sum, the scale multiply, the round and address logic with the
// registered tile store read, and the tint with the output register. The
// four-entry input queue holds beats while the output side is stalled.
// Reads of texels never written since reset return unspecified data. The
// user must write registers over the APB port only while no beat is in
// flight; the block itself does not enforce this.
module rotate_scale_sprite_sampler #(
    parameter int MAX_TILE_COLS = rss_pkg::DEF_MAX_TILE_COLS,
    parameter int MAX_TILE_ROWS = rss_pkg::DEF_MAX_TILE_ROWS,
    parameter int MAX_DEST_SPAN = rss_pkg::DEF_MAX_DEST_SPAN
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // texel_col, texel_row, texel_rgba, dest_dx, dest_dy
    input  logic [rss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_rgba
    output logic [rss_pkg::RGBA_W-1:0]      m_axis_tdata,
    // hit
    output logic                            m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rss_pkg::*;

    cfg_t      cfg_reg;
    reg_idx_t  reg_idx;
    logic      cfg_wr;
    q_item_t   front_item;
    q_item_t   q_head;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_COS_ANGLE:     cfg_reg.cos_angle     <= $signed(pwdata[15:0]);
                REG_SIN_ANGLE:     cfg_reg.sin_angle     <= $signed(pwdata[15:0]);
                REG_INVERSE_SCALE: cfg_reg.inverse_scale <= pwdata[23:0];
                REG_PIVOT_COL:     cfg_reg.pivot_col     <= $signed(pwdata[16:0]);
                REG_PIVOT_ROW:     cfg_reg.pivot_row     <= $signed(pwdata[16:0]);
                REG_TILE_COLS:     cfg_reg.tile_cols     <= pwdata[6:0];
                REG_TILE_ROWS:     cfg_reg.tile_rows     <= pwdata[6:0];
                REG_TINT_SETTING:
                begin
                    cfg_reg.tint_en   <= pwdata[32];
                    cfg_reg.tint_rgba <= pwdata[31:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COS_ANGLE:     prdata = CFG_DATA_W'(unsigned'(cfg_reg.cos_angle));
            REG_SIN_ANGLE:     prdata = CFG_DATA_W'(unsigned'(cfg_reg.sin_angle));
            REG_INVERSE_SCALE: prdata = CFG_DATA_W'(cfg_reg.inverse_scale);
            REG_PIVOT_COL:     prdata = CFG_DATA_W'(unsigned'(cfg_reg.pivot_col));
            REG_PIVOT_ROW:     prdata = CFG_DATA_W'(unsigned'(cfg_reg.pivot_row));
            REG_TILE_COLS:     prdata = CFG_DATA_W'(cfg_reg.tile_cols);
            REG_TILE_ROWS:     prdata = CFG_DATA_W'(cfg_reg.tile_rows);
            REG_TINT_SETTING:  prdata = CFG_DATA_W'({cfg_reg.tint_en, cfg_reg.tint_rgba});
            default:           prdata = '0;
        endcase
    end

    rss_front #(
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_TILE_ROWS (MAX_TILE_ROWS),
        .MAX_DEST_SPAN (MAX_DEST_SPAN)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (q_stat),
        .push          (q_push),
        .item          (front_item)
    );

    rss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .in_item (front_item),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    rss_back #(
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_TILE_ROWS (MAX_TILE_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head          (q_head),
        .stat          (q_stat),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
